[sv/plc_pkg.sv]
package plc_pkg;

  localparam int CAPACITY = 16;
  localparam int POS_W    = 8;
  localparam int VAL_W    = 32;
  localparam int STAT_W   = 2;
  localparam int IDX_W    = 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [STAT_W-1:0] ST_ELEMENT = 2'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  localparam logic [1:0] MODE_HOLD   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_ROTATE = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [POS_W-1:0] idx;
    logic [VAL_W-1:0] val;
  } cell_ctl_t;

endpackage

[sv/plc_cell.sv]
module plc_cell #(
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  plc_pkg::cell_ctl_t       ctl,
  input  logic [plc_pkg::VAL_W-1:0] from_left,
  input  logic [plc_pkg::VAL_W-1:0] from_right,
  output logic [plc_pkg::VAL_W-1:0] data
);
  import plc_pkg::*;

  logic [VAL_W-1:0] data_next;
  logic [POS_W-1:0] my_idx;

  assign my_idx = POS_W'(INDEX);

  always_comb begin
    data_next = data;
    case (ctl.mode)
      MODE_INSERT: begin
        if (my_idx == ctl.idx) begin
          data_next = ctl.val;
        end else if (my_idx > ctl.idx) begin
          data_next = from_left;
        end
      end
      MODE_DELETE: begin
        if (my_idx >= ctl.idx) begin
          data_next = from_right;
        end
      end
      MODE_ROTATE: data_next = from_right;
      default: data_next = data;
    endcase
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

[sv/positional_list_insert_delete.sv]
// Positional list: ordered list of up to CAPACITY signed 32-bit entries.
// Input channel (in_valid / in_stall): opcode, 1-based position, item_value.
// opcode insert places item_value at position 1..count+1, delete removes the
// entry at position 1..count. Output channel (out_valid / out_stall) carries
// one result per transaction step: after a good operation the whole list in
// order (status element, element_index from 0, last_result on the final one),
// or a single list-empty result; a bad position or an insert into a full list
// gives a single status result and leaves the list alone.
// Timing: the transaction is registered on acceptance, S_EXEC checks it and
// shifts the row of cells, then in S_EMIT the row rotates once round, the
// head cell feeding the output register for the first count steps. A new
// item is taken only after the rotation ends; a rejected item or an empty
// list ends sooner, with its status result. The first result is registered
// in S_EMIT, or in S_EXEC for a rejected item.
// in_stall is high from acceptance until the transaction finishes; the output
// register may still hold the final result while the next item is taken.
// When out_stall holds a result, it stays and a rotation still emitting pauses.
// Reset empties the list and clears out_valid; cell contents are not reset.
module positional_list_insert_delete #(
  parameter int CAPACITY = plc_pkg::CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [plc_pkg::POS_W-1:0]           position,
  input  logic signed [plc_pkg::VAL_W-1:0]    item_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [plc_pkg::STAT_W-1:0]          status,
  output logic signed [plc_pkg::VAL_W-1:0]    element_value,
  output logic [plc_pkg::IDX_W-1:0]           element_index,
  output logic                                last_result
);
  import plc_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = $clog2(CAPACITY);
  localparam int EW = ((CW > POS_W) ? CW : POS_W) + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state, state_next;
  logic             op_r;
  logic [POS_W-1:0] pos_r;
  logic [VAL_W-1:0] val_r;
  logic [CW-1:0]    count, count_next;
  logic [KW-1:0]    k, k_next;

  logic              out_valid_next;
  logic [STAT_W-1:0] status_next;
  logic [VAL_W-1:0]  value_next;
  logic [IDX_W-1:0]  index_next;
  logic              last_next;

  logic [VAL_W-1:0] cell_data [CAPACITY];
  cell_ctl_t        ctl;

  logic          accept;
  logic          slot_free;
  logic [EW-1:0] pos_e, cnt_e;
  logic          range_bad, list_full;
  logic          k_live, step;
  logic [CW-1:0] k_c;

  assign in_stall  = (state != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;

  assign pos_e = EW'(pos_r);
  assign cnt_e = EW'(count);
  assign range_bad = (pos_r == '0) ||
                     ((op_r == OP_INSERT) ? (pos_e > cnt_e + EW'(1)) : (pos_e > cnt_e));
  assign list_full = (cnt_e == EW'(CAPACITY));

  assign k_c    = CW'(k);
  assign k_live = (k_c < count);
  assign step   = k_live ? slot_free : 1'b1;

  always_comb begin
    state_next     = state;
    count_next     = count;
    k_next         = k;
    out_valid_next = out_valid && out_stall;
    status_next    = status;
    value_next     = element_value;
    index_next     = element_index;
    last_next      = last_result;
    ctl.mode       = MODE_HOLD;
    ctl.idx        = pos_r - POS_W'(1);
    ctl.val        = val_r;

    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (range_bad || (op_r == OP_INSERT && list_full)) begin
          if (slot_free) begin
            out_valid_next = 1'b1;
            status_next    = range_bad ? ST_RANGE : ST_FULL;
            value_next     = '0;
            index_next     = '0;
            last_next      = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          if (op_r == OP_INSERT) begin
            ctl.mode   = MODE_INSERT;
            count_next = count + CW'(1);
          end else begin
            ctl.mode   = MODE_DELETE;
            count_next = count - CW'(1);
          end
          k_next     = '0;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (count == '0) begin
          if (slot_free) begin
            out_valid_next = 1'b1;
            status_next    = ST_EMPTY;
            value_next     = '0;
            index_next     = '0;
            last_next      = 1'b1;
            state_next     = S_IDLE;
          end
        end else if (step) begin
          ctl.mode = MODE_ROTATE;
          if (k_live) begin
            out_valid_next = 1'b1;
            status_next    = ST_ELEMENT;
            value_next     = cell_data[0];
            index_next     = IDX_W'(k);
            last_next      = (k_c + CW'(1) == count);
          end
          if (k_c == CW'(CAPACITY - 1)) begin
            state_next = S_IDLE;
          end else begin
            k_next = k + KW'(1);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      plc_cell #(
        .INDEX(g)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .from_left (cell_data[(g + CAPACITY - 1) % CAPACITY]),
        .from_right(cell_data[(g + 1) % CAPACITY]),
        .data      (cell_data[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      k         <= k_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= opcode;
      pos_r <= position;
      val_r <= item_value;
    end
    status        <= status_next;
    element_value <= $signed(value_next);
    element_index <= index_next;
    last_result   <= last_next;
  end

endmodule

[sv/plc_checker.sv]
module plc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [plc_pkg::STAT_W-1:0]       status,
  input logic signed [plc_pkg::VAL_W-1:0] element_value,
  input logic [plc_pkg::IDX_W-1:0]        element_index,
  input logic                             last_result
);
  import plc_pkg::*;

  // busy straight after taking a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transaction");

  // status results stand alone
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_ELEMENT |-> last_result)
    else $error("status result not marked last");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_ELEMENT |-> element_value == '0 && element_index == '0)
    else $error("status result carries data");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) &&
      $stable(element_value) && $stable(element_index) && $stable(last_result))
    else $error("stalled result changed");

endmodule

bind positional_list_insert_delete plc_checker u_plc_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import plc_pkg::*;

  localparam int RANDOM_ITEMS = 300;
  localparam int N_DIRECTED   = 28;

  typedef struct packed {
    logic [STAT_W-1:0]       st;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        idx;
    logic                    last;
  } listing_t;

  typedef struct packed {
    logic                    fixed;
    logic [STAT_W-1:0]       fixed_st;
    logic                    op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
  } step_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic                    opcode = OP_INSERT;
  logic [POS_W-1:0]        position = '0;
  logic signed [VAL_W-1:0] item_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] element_value;
  logic [IDX_W-1:0]        element_index;
  logic                    last_result;

  // tags travelling with the driven transaction
  logic                    row_fixed = 1'b0;
  logic [STAT_W-1:0]       row_status = ST_ELEMENT;

  logic                    gaps_on = 1'b1;
  int                      mismatch_count = 0;

  logic signed [VAL_W-1:0] list_mirror [CAPACITY];
  int                      list_len = 0;
  listing_t                op_results [$];
  listing_t                listing_queue [$];
  listing_t                want;

  step_row_t directed_steps [N_DIRECTED] = '{
    '{1'b1, ST_RANGE,   OP_DELETE, 8'd1,   32'sh0000_0000},
    '{1'b1, ST_RANGE,   OP_INSERT, 8'd0,   32'sh0000_0000},
    '{1'b1, ST_RANGE,   OP_INSERT, 8'd2,   32'sh0000_0000},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd1,   32'sh7FFF_FFFF},
    '{1'b1, ST_EMPTY,   OP_DELETE, 8'd1,   32'sh0000_0000},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd1,   32'sh8000_0000},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd1,   32'shFFFF_FFFF},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd3,   32'sh7FFF_FFFF},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd2,   32'sh0000_0000},
    '{1'b1, ST_RANGE,   OP_DELETE, 8'd255, 32'sh0000_0000},
    '{1'b1, ST_RANGE,   OP_INSERT, 8'd255, 32'sh1234_5678},
    '{1'b1, ST_RANGE,   OP_DELETE, 8'd5,   32'sh0000_0000},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd1,   32'sh5555_5555},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd6,   32'shAAAA_AAAA},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd3,   32'sh0000_0001},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd8,   32'shFFFF_FFFE},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd5,   32'sh1234_5678},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd10,  32'sh8765_4321},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd2,   32'sh0F0F_0F0F},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd12,  32'shF0F0_F0F0},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd7,   32'sh7FFF_FFFE},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd14,  32'sh8000_0001},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd15,  32'sh00FF_00FF},
    '{1'b0, ST_ELEMENT, OP_INSERT, 8'd16,  32'shFF00_FF00},
    '{1'b1, ST_FULL,    OP_INSERT, 8'd17,  32'sh0000_0000},
    '{1'b1, ST_RANGE,   OP_INSERT, 8'd18,  32'sh0000_0000},
    '{1'b0, ST_ELEMENT, OP_DELETE, 8'd16,  32'sh0000_0000},
    '{1'b0, ST_ELEMENT, OP_DELETE, 8'd1,   32'sh0000_0000}
  };

  positional_list_insert_delete uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .position(position),
    .item_value(item_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .element_value(element_value),
    .element_index(element_index),
    .last_result(last_result)
  );

  always #10 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    if (mismatch_count < 100) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic listing_t lone_status(input logic [STAT_W-1:0] st);
    listing_t r;
    r = '0;
    r.st = st;
    r.last = 1'b1;
    return r;
  endfunction

  // updates the mirrored list and leaves the listing it causes in op_results
  function automatic void apply_list_op(input logic op, input logic [POS_W-1:0] pos,
                                        input logic signed [VAL_W-1:0] val);
    int i;
    int p;
    listing_t r;
    p = int'(pos);
    op_results.delete();
    if (op == OP_INSERT) begin
      if (p < 1 || p > list_len + 1) begin
        op_results.push_back(lone_status(ST_RANGE));
        return;
      end
      if (list_len >= CAPACITY) begin
        op_results.push_back(lone_status(ST_FULL));
        return;
      end
      for (i = list_len; i >= p; i--) list_mirror[i] = list_mirror[i - 1];
      list_mirror[p - 1] = val;
      list_len++;
    end else begin
      if (p < 1 || p > list_len) begin
        op_results.push_back(lone_status(ST_RANGE));
        return;
      end
      for (i = p - 1; i + 1 < list_len; i++) list_mirror[i] = list_mirror[i + 1];
      list_len--;
    end
    if (list_len == 0) begin
      op_results.push_back(lone_status(ST_EMPTY));
      return;
    end
    for (i = 0; i < list_len; i++) begin
      r.st = ST_ELEMENT;
      r.value = list_mirror[i];
      r.idx = IDX_W'(i);
      r.last = (i == list_len - 1);
      op_results.push_back(r);
    end
  endfunction

  // result check first, then prediction for a transaction taken at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (listing_queue.size() == 0) begin
          flag_mismatch($sformatf("unexpected result st=%0d val=%0d idx=%0d last=%0b",
                                  status, element_value, element_index, last_result));
        end else begin
          want = listing_queue.pop_front();
          if (status !== want.st || element_value !== want.value ||
              element_index !== want.idx || last_result !== want.last) begin
            flag_mismatch($sformatf(
              "got st=%0d val=%0d idx=%0d last=%0b, want st=%0d val=%0d idx=%0d last=%0b",
              status, element_value, element_index, last_result,
              want.st, want.value, want.idx, want.last));
          end
        end
      end
      if (in_valid && !in_stall) begin
        apply_list_op(opcode, position, item_value);
        if (row_fixed) begin
          listing_queue.push_back(lone_status(row_status));
        end else begin
          foreach (op_results[k]) listing_queue.push_back(op_results[k]);
        end
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(0, 99) < 9);
  end

  // called and returning at a falling edge
  task automatic send_op(input logic op, input logic [POS_W-1:0] pos,
                         input logic signed [VAL_W-1:0] val, input logic fixed,
                         input logic [STAT_W-1:0] fixed_st);
    while (gaps_on && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    position <= pos;
    item_value <= val;
    row_fixed <= fixed;
    row_status <= fixed_st;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_listing();
    in_valid <= 1'b0;
    do @(negedge clk); while (listing_queue.size() != 0);
  endtask

  initial begin
    int n;
    int p;
    int roll;
    int insert_lean;
    logic op;
    logic signed [VAL_W-1:0] v;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (n = 0; n < N_DIRECTED; n++) begin
      send_op(directed_steps[n].op, directed_steps[n].pos, directed_steps[n].val,
              directed_steps[n].fixed, directed_steps[n].fixed_st);
    end
    drain_listing();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      gaps_on = !(n >= 120 && n < 200);
      insert_lean = ((n / 40) % 2 == 0) ? 70 : 30;
      case ($urandom_range(0, 9))
        0: v = 32'sh7FFF_FFFF;
        1: v = 32'sh8000_0000;
        2: v = ($urandom_range(0, 1) == 1) ? 32'sh0000_0000 : 32'shFFFF_FFFF;
        default: v = $urandom();
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        op = 1'($urandom_range(0, 1));
        p = $urandom_range(0, 255);
      end else begin
        if (list_len == 0) begin
          op = OP_INSERT;
        end else if (list_len == CAPACITY) begin
          op = ($urandom_range(0, 99) < 15) ? OP_INSERT : OP_DELETE;
        end else begin
          op = ($urandom_range(0, 99) < insert_lean) ? OP_INSERT : OP_DELETE;
        end
        p = (op == OP_INSERT) ? $urandom_range(1, list_len + 1) : $urandom_range(1, list_len);
      end
      send_op(op, POS_W'(p), v, 1'b0, ST_ELEMENT);
      if (n == 150) begin
        drain_listing();
      end
    end

    gaps_on = 1'b0;
    drain_listing();
    repeat (CAPACITY + 4) @(negedge clk);
    if (listing_queue.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", listing_queue.size()));
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

[positional_list_insert_delete.f]
sv/plc_pkg.sv
sv/plc_cell.sv
sv/positional_list_insert_delete.sv
sv/plc_checker.sv
tb/sv/tb_top.sv
